// ===== hdl/pairwise_euclidean_distances_top_assert.svh =====
// assertion macros used by the top-level rtl file
`ifndef PAIRWISE_EUCLIDEAN_DISTANCES_TOP_ASSERT_SVH
`define PAIRWISE_EUCLIDEAN_DISTANCES_TOP_ASSERT_SVH

// property must hold at every clock edge outside reset
`define PWD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// condition must never be seen outside reset
`define PWD_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// ===== hdl/pwd_pkg.sv =====
`default_nettype none
package pwd_pkg;

  // input and output word widths
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 32;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_NUM_ROWS   = 2'd0;
  localparam logic [1:0] CFG_NUM_COLS   = 2'd1;
  localparam logic [1:0] CFG_PTS_IN_COL = 2'd2;

  localparam int unsigned SIZE_W  = 7;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned ELEM_W  = 16;
  localparam int unsigned SUM_W   = 40;
  localparam int unsigned ROOT_W  = SUM_W / 2;
  localparam int unsigned DIST_W  = 19;
  localparam logic [SIZE_W-1:0] RESULT_LIMIT = 7'd64;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_DRAIN,
    ST_HAND
  } pwd_state_e;

  // travels with each radicand through the root unit
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             last;
  } pwd_tag_t;

endpackage
`default_nettype wire

// ===== hdl/pairwise_euclidean_distances_top.sv =====
// load word: written to the element store at accept
// query word: for each point the coordinates go through the shared subtract/square/accumulate
// path fed by the two store read ports; the 20 step root of one point overlaps the next
// point's accumulation; the input is not ready while a query walks its points
// reset: sizes 64 by 64, rows are points; store contents undefined until written
`default_nettype none
`include "pairwise_euclidean_distances_top_assert.svh"
module pairwise_euclidean_distances_top #(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 64
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [1:0]                     cfg_idx_i,
  input  wire logic [pwd_pkg::SIZE_W-1:0]     cfg_wdata_i,
  input  wire logic                           s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // elem_row, elem_col, value, point_index, zero pad
  input  wire logic [pwd_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // kind
  input  wire logic                           s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  // distance, other_point, zero pad
  output logic [pwd_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o,
  output logic                                m_axis_tlast_o
);
  import pwd_pkg::*;

  localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned RW    = $clog2(MAX_ROWS);
  localparam int unsigned CW    = $clog2(MAX_COLS);

  function automatic logic [AW-1:0] addr_of(logic [7:0] r, logic [7:0] c);
    return AW'(r[RW-1:0]) * AW'(MAX_COLS) + AW'(c[CW-1:0]);
  endfunction

  // configuration
  logic [SIZE_W-1:0] num_rows_q, num_cols_q;
  logic              pts_in_col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q   <= 7'd64;
      num_cols_q   <= 7'd64;
      pts_in_col_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_NUM_ROWS:   num_rows_q   <= cfg_wdata_i;
        CFG_NUM_COLS:   num_cols_q   <= cfg_wdata_i;
        CFG_PTS_IN_COL: pts_in_col_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  logic [SIZE_W-1:0] rows_eff, cols_eff, pts_raw, npts_in, ndim_in;

  always_comb begin
    if (num_rows_q == '0)                   rows_eff = 7'd1;
    else if (int'(num_rows_q) > MAX_ROWS)   rows_eff = SIZE_W'(MAX_ROWS);
    else                                    rows_eff = num_rows_q;
    if (num_cols_q == '0)                   cols_eff = 7'd1;
    else if (int'(num_cols_q) > MAX_COLS)   cols_eff = SIZE_W'(MAX_COLS);
    else                                    cols_eff = num_cols_q;
    pts_raw = pts_in_col_q ? cols_eff : rows_eff;
    ndim_in = pts_in_col_q ? rows_eff : cols_eff;
    npts_in = (pts_raw > RESULT_LIMIT) ? RESULT_LIMIT : pts_raw;
  end

  // input word fields
  logic [IDX_W-1:0]  in_row, in_col, in_point;
  logic [ELEM_W-1:0] in_value;
  logic              in_accept, in_query, load_we;

  assign in_row    = s_axis_tdata_i[5:0];
  assign in_col    = s_axis_tdata_i[11:6];
  assign in_value  = s_axis_tdata_i[27:12];
  assign in_point  = s_axis_tdata_i[33:28];
  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign in_query  = in_accept && (s_axis_tuser_i == KIND_QUERY);
  assign load_we   = in_accept && (s_axis_tuser_i == KIND_LOAD)
                     && (int'(in_row) < MAX_ROWS) && (int'(in_col) < MAX_COLS);

  // sequencer
  pwd_state_e        state_q, state_d;
  logic [IDX_W-1:0]  j_q, j_d, p_q;
  logic [SIZE_W-1:0] k_q, k_d, npts_q, ndim_q;
  logic              by_col_q;
  logic              issue, sq_start, sq_ready, sq_done, out_load;
  logic              j_last;
  logic              v1_q, v2_q, v3_q;

  assign j_last = (SIZE_W'(j_q) + 7'd1) == npts_q;

  assign s_axis_tready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d         = state_q;
    j_d             = j_q;
    k_d             = k_q;
    issue           = 1'b0;
    sq_start        = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_query && (SIZE_W'(in_point) < npts_in)) begin
          j_d     = '0;
          k_d     = '0;
          state_d = (in_point == '0) ? ST_HAND : ST_ACCUM;
        end
      end
      ST_ACCUM: begin
        issue = 1'b1;
        k_d   = k_q + 7'd1;
        if (k_q == ndim_q - 7'd1) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!v1_q && !v2_q && !v3_q) begin
          state_d = ST_HAND;
        end
      end
      ST_HAND: begin
        if (sq_ready) begin
          sq_start = 1'b1;
          if (j_last) begin
            state_d = ST_IDLE;
          end else begin
            j_d     = j_q + 1'b1;
            k_d     = '0;
            state_d = ((j_q + 1'b1) == p_q) ? ST_HAND : ST_ACCUM;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_query) begin
      p_q      <= in_point;
      npts_q   <= npts_in;
      ndim_q   <= ndim_in;
      by_col_q <= pts_in_col_q;
    end
  end

  // store addressing: a is the queried point, b the other point
  logic [7:0]    a_row, a_col, b_row, b_col;
  logic [AW-1:0] raddr_a, raddr_b, waddr;
  logic [15:0]   rdata_a, rdata_b;

  always_comb begin
    a_row = by_col_q ? 8'(k_q) : 8'(p_q);
    a_col = by_col_q ? 8'(p_q) : 8'(k_q);
    b_row = by_col_q ? 8'(k_q) : 8'(j_q);
    b_col = by_col_q ? 8'(j_q) : 8'(k_q);
  end

  assign raddr_a = addr_of(a_row, a_col);
  assign raddr_b = addr_of(b_row, b_col);
  assign waddr   = addr_of(8'(in_row), 8'(in_col));

  pwd_store #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_store (
    .clk_i    (clk_i),
    .we_i     (load_we),
    .waddr_i  (waddr),
    .wdata_i  (in_value),
    .raddr_a_i(raddr_a),
    .raddr_b_i(raddr_b),
    .rdata_a_o(rdata_a),
    .rdata_b_o(rdata_b)
  );

  // shared difference, square and accumulate path
  logic signed [ELEM_W:0] diff;
  logic [ELEM_W:0]        diff_abs;
  logic [ELEM_W-1:0]      absd_q;
  logic [2*ELEM_W-1:0]    prod_q;
  logic [SUM_W-1:0]       acc_q, acc_d;

  assign diff     = {rdata_a[15], rdata_a} - {rdata_b[15], rdata_b};
  assign diff_abs = diff[ELEM_W] ? (~diff + 1'b1) : diff;

  always_comb begin
    acc_d = acc_q;
    if (in_query || sq_start) begin
      acc_d = '0;
    end else if (v3_q) begin
      acc_d = acc_q + SUM_W'(prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      acc_q <= '0;
    end else begin
      v1_q  <= issue;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    absd_q <= diff_abs[ELEM_W-1:0];
    prod_q <= absd_q * absd_q;
  end

  // root unit
  pwd_tag_t          sq_tag_in, sq_tag;
  logic [ROOT_W-1:0] sq_root;

  assign sq_tag_in.idx  = j_q;
  assign sq_tag_in.last = j_last;

  pwd_isqrt u_isqrt (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (sq_start),
    .rad_i    (acc_q),
    .tag_i    (sq_tag_in),
    .consume_i(out_load),
    .ready_o  (sq_ready),
    .done_o   (sq_done),
    .root_o   (sq_root),
    .tag_o    (sq_tag)
  );

  // output register
  logic              out_valid_q;
  logic [DIST_W-1:0] dist_q;
  logic [IDX_W-1:0]  other_q;
  logic              last_q;

  assign out_load = sq_done && (!out_valid_q || m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      // saturate roots that do not fit the distance field
      dist_q  <= sq_root[ROOT_W-1] ? '1 : sq_root[DIST_W-1:0];
      other_q <= sq_tag.idx;
      last_q  <= sq_tag.last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OUT_DATA_W - DIST_W - IDX_W)'(0), other_q, dist_q};
  assign m_axis_tlast_o  = last_q;

  `PWD_NEVER(a_ready_pipe_empty, s_axis_tready_o && (v1_q || v2_q || v3_q),
             "input ready while products still in flight")
  `PWD_ASSERT(a_start_when_free, sq_start |-> sq_ready,
              "root unit started while busy")
  `PWD_ASSERT(a_diag_zero, (state_q == ST_HAND && j_q == p_q) |-> (acc_q == '0),
              "nonzero sum handed off for the queried point itself")
  `PWD_ASSERT(a_issue_range, (state_q == ST_ACCUM) |-> (k_q < ndim_q),
              "coordinate read beyond the dimensions in use")

endmodule
`default_nettype wire

// ===== hdl/pwd_store.sv =====
`default_nettype none
module pwd_store #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [15:0]   wdata_i,
  input  wire logic [AW-1:0] raddr_a_i,
  input  wire logic [AW-1:0] raddr_b_i,
  output logic      [15:0]   rdata_a_o,
  output logic      [15:0]   rdata_b_o
);

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata_a_q, rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_q <= mem[raddr_a_i];
    rdata_b_q <= mem[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule
`default_nettype wire

// ===== hdl/pwd_isqrt.sv =====
`default_nettype none
module pwd_isqrt (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [pwd_pkg::SUM_W-1:0] rad_i,
  input  wire pwd_pkg::pwd_tag_t         tag_i,
  input  wire logic                      consume_i,
  output logic                           ready_o,
  output logic                           done_o,
  output logic [pwd_pkg::ROOT_W-1:0]     root_o,
  output pwd_pkg::pwd_tag_t              tag_o
);
  import pwd_pkg::*;

  localparam int unsigned CNT_W = $clog2(ROOT_W);

  logic [SUM_W-1:0]  x_q, x_d;
  logic [ROOT_W+1:0] rem_q, rem_d, rem_sh, trial;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d, done_q, done_d;
  pwd_tag_t          tag_q, tag_d;

  // one result bit per cycle, restoring digit recurrence
  assign rem_sh = {rem_q[ROOT_W-1:0], x_q[SUM_W-1 -: 2]};
  assign trial  = {root_q, 2'b01};

  always_comb begin
    x_d    = x_q;
    rem_d  = rem_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = done_q;
    tag_d  = tag_q;
    if (consume_i) begin
      done_d = 1'b0;
    end
    if (start_i) begin
      x_d    = rad_i;
      rem_d  = '0;
      root_d = '0;
      cnt_d  = '0;
      busy_d = 1'b1;
      tag_d  = tag_i;
    end else if (busy_q) begin
      x_d   = {x_q[SUM_W-3:0], 2'b00};
      cnt_d = cnt_q + 1'b1;
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[ROOT_W-2:0], 1'b0};
      end
      if (cnt_q == CNT_W'(ROOT_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    tag_q  <= tag_d;
  end

  assign ready_o = !busy_q && !done_q;
  assign done_o  = done_q;
  assign root_o  = root_q;
  assign tag_o   = tag_q;

endmodule
`default_nettype wire
